>>> hdl/gibs_pkg.sv
// Package for the greedy overlap box suppression block.
// Holds sizes, box and status types, the controller state type and the
// command and status structs shared by the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package gibs_pkg;

  localparam int MAX_KEPT   = 128;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W      = $clog2(MAX_KEPT + 1);
  localparam int TAG_W      = 15;
  localparam int TOT_W      = 8;
  localparam int LIM_W      = 16;
  localparam int DIM_W      = COORD_BITS;
  localparam int AREA_W     = 2 * COORD_BITS;
  localparam int UNI_W      = AREA_W + 1;
  localparam int PROD_W     = LIM_W + UNI_W;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(13107);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } box_t;

  localparam int ENTRY_W = $bits(box_t) + AREA_W;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_AREA = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic capture;
    logic prep;
    logic issue;
    logic decide;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad_box;
    logic scan_done;
    logic pipe_busy;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/gibs_if.sv
// Channel interfaces of the box suppression block: input boxes, results
// and the threshold register write. Depends on gibs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gibs_box_if import gibs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             first_of_set;
  coord_t           box_left;
  coord_t           box_top;
  coord_t           box_right;
  coord_t           box_bottom;
  logic [TAG_W-1:0] candidate_tag;

  modport source (output valid, first_of_set, box_left, box_top, box_right, box_bottom,
                  candidate_tag, input ready);
  modport sink   (input valid, first_of_set, box_left, box_top, box_right, box_bottom,
                  candidate_tag, output ready);
endinterface

interface gibs_res_if import gibs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kept;
  status_e          status;
  logic [TAG_W-1:0] tag_out;
  logic [TOT_W-1:0] kept_total;

  modport source (output valid, kept, status, tag_out, kept_total, input ready);
  modport sink   (input valid, kept, status, tag_out, kept_total, output ready);
endinterface

interface gibs_cfg_if import gibs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hdl/greedy_iou_box_suppression.sv
// Greedy overlap suppression of score-ordered boxes, one result per box.
// A new request is taken only after the previous box has been decided; a
// non-positive area box skips the scan of the kept list. A held result stalls
// the decision of the next box. Reset clears the kept count, the controller
// and the output valid and returns the threshold to 13107.
`timescale 1ns / 1ps
`default_nettype none

module greedy_iou_box_suppression import gibs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  gibs_box_if.sink   box_i,
  gibs_res_if.source res_o,
  gibs_cfg_if.sink   cfg_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  assign box_i.ready = in_ready;

  gibs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (box_i.valid),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  gibs_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .box_i  (box_i),
    .res_o  (res_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  a_kept_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kept) |-> (res_o.status == STAT_OK))
    else $error("kept result carries an error status");

  a_full_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status == STAT_FULL)) |->
      (res_o.kept_total == TOT_W'(MAX_KEPT)))
    else $error("full status while the kept list is not full");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (box_i.valid && box_i.ready) |=> !box_i.ready)
    else $error("new request taken while a box is still in work");

  a_no_issue_in_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.decide |-> (!stat.pipe_busy && !cmd.issue))
    else $error("decision made while overlap tests are in flight");

endmodule

`default_nettype wire

>>> hdl/gibs_ctrl.sv
// Controller state machine of the box suppression block.
// Sequences capture, area, scan, drain and decision; depends on gibs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gibs_ctrl import gibs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  dp_stat_t  stat_i,
  output logic      in_ready_o,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_AREA;
        end
      end
      ST_AREA: begin
        cmd_o.prep = 1'b1;
        state_d    = stat_i.bad_box ? ST_DECIDE : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat_i.out_free) begin
          cmd_o.decide = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/gibs_dp.sv
// Datapath of the box suppression block: candidate registers, kept-box
// memory, the pipelined overlap test, the threshold register and the
// result register. Depends on gibs_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module gibs_dp import gibs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gibs_box_if.sink    box_i,
  gibs_res_if.source  res_o,
  gibs_cfg_if.sink    cfg_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_stat_t    stat_o
);

  box_t              box_q;
  logic [TAG_W-1:0]  tag_q;
  logic [AREA_W-1:0] area_q;
  logic [LIM_W-1:0]  limit_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  scan_q;
  logic              sticky_q;

  logic [ENTRY_W-1:0] mem [MAX_KEPT];
  logic [ENTRY_W-1:0] rd_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  logic [DIM_W-1:0]  iw_q, ih_q;
  logic [AREA_W-1:0] ka2_q, ka3_q;
  logic [AREA_W-1:0] inter3_q, inter4_q;
  logic [UNI_W-1:0]  uni_q;
  logic [PROD_W-1:0] prod_q, ish_q;

  logic              out_valid_q;
  logic              kept_q;
  status_e           status_q;
  logic [TAG_W-1:0]  tag_out_q;
  logic [TOT_W-1:0]  total_q;

  logic signed [DIM_W:0] dx, dy;
  logic                  bad;
  logic                  full;
  logic                  keep;
  logic                  store;

  box_t                  kb;
  logic [AREA_W-1:0]     ka;
  coord_t                il, it, ir, ib;
  logic signed [DIM_W:0] idx_w, idy_w;
  logic [DIM_W-1:0]      iw_d, ih_d;

  assign dx   = {box_q.right[DIM_W-1], box_q.right} - {box_q.left[DIM_W-1], box_q.left};
  assign dy   = {box_q.bottom[DIM_W-1], box_q.bottom} - {box_q.top[DIM_W-1], box_q.top};
  assign bad  = (dx <= 0) || (dy <= 0);
  assign full = (count_q >= CNT_W'(MAX_KEPT));
  assign keep = !bad && !sticky_q && !full;
  assign store = cmd_i.decide && keep;

  assign kb = rd_q[ENTRY_W-1:AREA_W];
  assign ka = rd_q[AREA_W-1:0];

  always_comb begin
    il    = (kb.left   > box_q.left)   ? kb.left   : box_q.left;
    it    = (kb.top    > box_q.top)    ? kb.top    : box_q.top;
    ir    = (kb.right  < box_q.right)  ? kb.right  : box_q.right;
    ib    = (kb.bottom < box_q.bottom) ? kb.bottom : box_q.bottom;
    idx_w = {ir[DIM_W-1], ir} - {il[DIM_W-1], il};
    idy_w = {ib[DIM_W-1], ib} - {it[DIM_W-1], it};
    iw_d  = (idx_w > 0) ? idx_w[DIM_W-1:0] : '0;
    ih_d  = (idy_w > 0) ? idy_w[DIM_W-1:0] : '0;
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.capture && box_i.first_of_set) begin
      count_d = '0;
    end else if (store) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      limit_q     <= LIMIT_RESET;
      scan_q      <= '0;
      sticky_q    <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_i.valid) begin
        limit_q <= cfg_i.data;
      end
      if (cmd_i.prep) begin
        scan_q <= '0;
      end else if (cmd_i.issue) begin
        scan_q <= scan_q + CNT_W'(1);
      end
      if (cmd_i.prep) begin
        sticky_q <= 1'b0;
      end else if (v5_q && (ish_q > prod_q)) begin
        sticky_q <= 1'b1;
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      if (cmd_i.decide) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[count_q[IDX_W-1:0]] <= {box_q, area_q};
    end
    if (cmd_i.issue) begin
      rd_q <= mem[scan_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      box_q.left   <= box_i.box_left;
      box_q.top    <= box_i.box_top;
      box_q.right  <= box_i.box_right;
      box_q.bottom <= box_i.box_bottom;
      tag_q        <= box_i.candidate_tag;
    end
    if (cmd_i.prep) begin
      area_q <= AREA_W'(dx[DIM_W-1:0]) * AREA_W'(dy[DIM_W-1:0]);
    end
    iw_q     <= iw_d;
    ih_q     <= ih_d;
    ka2_q    <= ka;
    inter3_q <= AREA_W'(iw_q) * AREA_W'(ih_q);
    ka3_q    <= ka2_q;
    uni_q    <= UNI_W'(ka3_q) + UNI_W'(area_q) - UNI_W'(inter3_q);
    inter4_q <= inter3_q;
    prod_q   <= PROD_W'(limit_q) * PROD_W'(uni_q);
    ish_q    <= PROD_W'(inter4_q) << LIM_W;
    if (cmd_i.decide) begin
      kept_q    <= keep;
      tag_out_q <= tag_q;
      total_q   <= TOT_W'(keep ? count_q + CNT_W'(1) : count_q);
      if (bad) begin
        status_q <= STAT_BAD_AREA;
      end else if (!sticky_q && full) begin
        status_q <= STAT_FULL;
      end else begin
        status_q <= STAT_OK;
      end
    end
  end

  assign cfg_i.ready = 1'b1;

  assign res_o.valid      = out_valid_q;
  assign res_o.kept       = kept_q;
  assign res_o.status     = status_q;
  assign res_o.tag_out    = tag_out_q;
  assign res_o.kept_total = total_q;

  assign stat_o.bad_box   = bad;
  assign stat_o.scan_done = (scan_q >= count_q);
  assign stat_o.pipe_busy = v1_q || v2_q || v3_q || v4_q || v5_q;
  assign stat_o.out_free  = !out_valid_q || res_o.ready;

endmodule

`default_nettype wire

>>> test/greedy_iou_box_suppression_test.sv
// Testbench for greedy_iou_box_suppression: drives score-ordered boxes and threshold
// writes, and checks each result against a scoreboard that mirrors the kept-box list.
// Depends on gibs_pkg, the gibs channel interfaces and the block itself.
`timescale 1ns / 1ps

module greedy_iou_box_suppression_test import gibs_pkg::*; ();

  localparam int STALL_LIMIT = 20000;
  localparam int SQUEEZE_LEN = 1500;

  typedef struct packed {
    logic             first;
    box_t             box;
    logic [TAG_W-1:0] tag;
  } box_req_t;

  typedef struct packed {
    logic             kept;
    status_e          status;
    logic [TAG_W-1:0] tag;
    logic [TOT_W-1:0] total;
  } verdict_t;

  class suppression_scoreboard;
    box_t              kept_box [MAX_KEPT];
    logic [AREA_W-1:0] kept_area [MAX_KEPT];
    int                kept_count;
    logic [LIM_W-1:0]  iou_limit;
    verdict_t          awaited[$];
    int                mismatches;

    function new();
      kept_count = 0;
      iou_limit  = LIMIT_RESET;
      mismatches = 0;
    endfunction

    function longint sx(coord_t v);
      return longint'(v);
    endfunction

    function bit too_close(box_t k, logic [AREA_W-1:0] ka, box_t c, logic [AREA_W-1:0] ca);
      longint l, t, r, b;
      longint unsigned iw, ih, inter, uni, lim;
      l = (sx(k.left) > sx(c.left)) ? sx(k.left) : sx(c.left);
      t = (sx(k.top) > sx(c.top)) ? sx(k.top) : sx(c.top);
      r = (sx(k.right) < sx(c.right)) ? sx(k.right) : sx(c.right);
      b = (sx(k.bottom) < sx(c.bottom)) ? sx(k.bottom) : sx(c.bottom);
      iw = (r > l) ? longint'(r - l) : 0;
      ih = (b > t) ? longint'(b - t) : 0;
      inter = iw * ih;
      uni = longint'(ka) + longint'(ca) - inter;
      lim = longint'(iou_limit);
      return (inter << 16) > (lim * uni);
    endfunction

    function void set_limit(logic [LIM_W-1:0] v);
      iou_limit = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_box(box_req_t r);
      verdict_t          v;
      logic [AREA_W-1:0] area;
      bit                hit;
      int                i;
      if (r.first) kept_count = 0;
      v.kept   = 1'b0;
      v.status = STAT_OK;
      v.tag    = r.tag;
      if (sx(r.box.right) <= sx(r.box.left) || sx(r.box.bottom) <= sx(r.box.top)) begin
        v.status = STAT_BAD_AREA;
      end else begin
        area = AREA_W'((sx(r.box.right) - sx(r.box.left)) *
                       (sx(r.box.bottom) - sx(r.box.top)));
        hit = 1'b0;
        for (i = 0; i < kept_count && !hit; i++) begin
          if (too_close(kept_box[i], kept_area[i], r.box, area)) hit = 1'b1;
        end
        if (!hit) begin
          if (kept_count >= MAX_KEPT) begin
            v.status = STAT_FULL;
          end else begin
            kept_box[kept_count]  = r.box;
            kept_area[kept_count] = area;
            kept_count++;
            v.kept = 1'b1;
          end
        end
      end
      v.total = TOT_W'(kept_count);
      awaited = {awaited, v};
    endfunction

    function void check_result(logic kept, status_e status, logic [TAG_W-1:0] tag,
                               logic [TOT_W-1:0] total);
      verdict_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kept %0b status %0d tag %0d total %0d",
                   kept, status, tag, total);
        return;
      end
      want = awaited.pop_front();
      if (want.kept !== kept || want.status !== status || want.tag !== tag ||
          want.total !== total) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected kept %0b status %0d tag %0d total %0d",
                   want.kept, want.status, want.tag, want.total);
          $display("          got kept %0b status %0d tag %0d total %0d",
                   kept, status, tag, total);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   steady = 1'b0;
  int   sent_items = 0;

  gibs_box_if box_bus ();
  gibs_res_if res_bus ();
  gibs_cfg_if cfg_bus ();

  suppression_scoreboard sb = new();

  greedy_iou_box_suppression dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .box_i  (box_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  always #5 clk_i = ~clk_i;

  function automatic coord_t clamp_coord(int v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic box_req_t make_req(bit first, int l, int t, int r, int b, int tag);
    box_req_t q;
    q.first      = first;
    q.box.left   = clamp_coord(l);
    q.box.top    = clamp_coord(t);
    q.box.right  = clamp_coord(r);
    q.box.bottom = clamp_coord(b);
    q.tag        = TAG_W'(tag);
    return q;
  endfunction

  task automatic send_box(input box_req_t r);
    while (!steady && $urandom_range(0, 99) < 14) begin
      box_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    box_bus.valid         <= 1'b1;
    box_bus.first_of_set  <= r.first;
    box_bus.box_left      <= r.box.left;
    box_bus.box_top       <= r.box.top;
    box_bus.box_right     <= r.box.right;
    box_bus.box_bottom    <= r.box.bottom;
    box_bus.candidate_tag <= r.tag;
    @(posedge clk_i);
    while (!box_bus.ready) @(posedge clk_i);
    sb.note_box(r);
    sent_items++;
  endtask

  task automatic drain();
    box_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic send_cluster_set(input int len);
    int       cx, cy, spread, i, x0, y0, w, h;
    box_req_t r;
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 2))
      0: spread = 8;
      1: spread = 200;
      default: spread = 4000;
    endcase
    for (i = 0; i < len; i++) begin
      w  = $urandom_range(1, spread);
      h  = $urandom_range(1, spread);
      x0 = cx + int'($urandom_range(0, spread)) - spread / 2;
      y0 = cy + int'($urandom_range(0, spread)) - spread / 2;
      r  = make_req(i == 0, x0, y0, x0 + w, y0 + h, $urandom);
      if ($urandom_range(0, 24) == 0) r.box.right = r.box.left - coord_t'($urandom_range(0, 2));
      if ($urandom_range(0, 24) == 0) r.box.bottom = r.box.top - coord_t'($urandom_range(0, 2));
      send_box(r);
    end
  endtask

  // Boxes on a grid never intersect, so none is suppressed and the list runs full.
  task automatic send_fill_set(input int len);
    int bx, by, i, x0, y0;
    bx = int'($urandom_range(0, 64000)) - 32768;
    by = int'($urandom_range(0, 64000)) - 32768;
    for (i = 0; i < len; i++) begin
      x0 = bx + (i % 16) * 64;
      y0 = by + (i / 16) * 64;
      send_box(make_req(i == 0, x0, y0, x0 + $urandom_range(1, 64), y0 + $urandom_range(1, 64),
                        $urandom));
    end
  endtask

  task automatic send_noise();
    box_req_t r;
    r.first      = $urandom_range(0, 1);
    r.box.left   = coord_t'($urandom);
    r.box.top    = coord_t'($urandom);
    r.box.right  = coord_t'($urandom);
    r.box.bottom = coord_t'($urandom);
    r.tag        = TAG_W'($urandom);
    send_box(r);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid === 1'b1 && res_bus.ready)
      sb.check_result(res_bus.kept, res_bus.status, res_bus.tag_out, res_bus.kept_total);
  end

  // The receiver holds off once for a long stretch so that the block backs up.
  initial begin : result_sink
    int seen, hold;
    bit squeezed;
    seen = 0;
    hold = 0;
    squeezed = 1'b0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_bus.valid && res_bus.ready) seen++;
      if (!squeezed && seen >= 200) begin
        squeezed = 1'b1;
        hold = SQUEEZE_LEN;
      end
      if (hold > 0) begin
        hold--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= steady || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((box_bus.valid && box_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int               phase, goal, len;
    logic [LIM_W-1:0] lim;
    rst_ni                <= 1'b0;
    box_bus.valid         <= 1'b0;
    box_bus.first_of_set  <= 1'b0;
    box_bus.box_left      <= '0;
    box_bus.box_top       <= '0;
    box_bus.box_right     <= '0;
    box_bus.box_bottom    <= '0;
    box_bus.candidate_tag <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.data          <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-range box, duplicate, degenerate boxes, touching edges, corner sliver.
    send_box(make_req(1, -32768, -32768, 32767, 32767, 0));
    send_box(make_req(0, -32768, -32768, 32767, 32767, 32767));
    send_box(make_req(0, 5, 5, 5, 10, 1));
    send_box(make_req(1, 0, 10, 20, 3, 2));
    send_box(make_req(0, 0, 0, 16, 16, 3));
    send_box(make_req(0, 16, 0, 32, 16, 4));
    send_box(make_req(0, -32768, 32000, -32767, 32767, 5));
    drain();
    // Overlap exactly at one half is kept, above it is suppressed.
    write_limit(16'd32768);
    send_box(make_req(1, 0, 0, 3, 1, 6));
    send_box(make_req(0, 1, 0, 4, 1, 7));
    send_box(make_req(0, 0, 0, 2, 1, 8));
    drain();
    // A zero threshold suppresses any positive intersection.
    write_limit(16'd0);
    send_box(make_req(1, 100, 100, 200, 200, 9));
    send_box(make_req(0, 199, 199, 300, 300, 10));
    send_box(make_req(0, 200, 100, 300, 200, 11));
    drain();
    write_limit(16'hFFFF);
    send_box(make_req(1, -50, -50, 50, 50, 12));
    send_box(make_req(0, -50, -50, 50, 50, 13));
    send_box(make_req(0, -50, -50, 50, 49, 14));

    for (phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: lim = 16'd0;
        1: lim = 16'hFFFF;
        2: lim = 16'd32768;
        3: lim = LIMIT_RESET;
        5: lim = 16'd1;
        7: lim = 16'hFFFE;
        default: lim = LIM_W'($urandom_range(0, 65535));
      endcase
      write_limit(lim);
      steady = (phase == 3);
      goal = sent_items + 150;
      if (phase == 1 || phase == 5) send_fill_set(130 + $urandom_range(0, 10));
      while (sent_items < goal) begin
        if ($urandom_range(0, 99) < 80) begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 10);
          send_cluster_set(len);
        end else begin
          repeat ($urandom_range(1, 4)) send_noise();
        end
      end
    end
    steady = 1'b0;

    drain();
    repeat (150) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
